>>> rtl/core/retransmit_pool_tracker_top_assert.svh
// Assertion macros for the retransmit pool tracker.
// Every macro expects clk and arst_n in scope.
`ifndef RETRANSMIT_POOL_TRACKER_TOP_ASSERT_SVH
`define RETRANSMIT_POOL_TRACKER_TOP_ASSERT_SVH

// cond must hold at every edge out of reset
`define RPT_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define RPT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// cons must hold in the cycle after ante
`define RPT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/rpt_pkg.sv
// ----------------------------------------------------------------------------
// rpt_pkg
// Types, codes and constants shared by the retransmit pool tracker modules.
// ----------------------------------------------------------------------------
`default_nettype none
package rpt_pkg;

	localparam int SLOTS   = 16;
	localparam int SIDX_W  = $clog2(SLOTS);
	localparam int ID_WRAP = 32760;

	localparam logic [15:0] SEND_WAIT_RST      = 16'd10;
	localparam logic [15:0] REMOVE_TIMEOUT_RST = 16'd1000;
	localparam logic [3:0]  RETRY_LIMIT_RST    = 4'd5;

	// register indexes
	localparam logic [1:0] REG_SEND_WAIT      = 2'd0;
	localparam logic [1:0] REG_REMOVE_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_RETRY_LIMIT    = 2'd2;

	// item kinds
	localparam logic [1:0] KIND_ENQ  = 2'd0;
	localparam logic [1:0] KIND_TICK = 2'd1;
	localparam logic [1:0] KIND_ACK  = 2'd2;
	localparam logic [1:0] KIND_NACK = 2'd3;

	// result events
	localparam logic [2:0] EV_ENQUEUED = 3'd0;
	localparam logic [2:0] EV_FULL     = 3'd1;
	localparam logic [2:0] EV_SEND     = 3'd2;
	localparam logic [2:0] EV_FAILED   = 3'd3;
	localparam logic [2:0] EV_SUCCESS  = 3'd4;
	localparam logic [2:0] EV_DONE     = 3'd5;

	localparam logic [3:0] SEND_COUNT_MAX = 4'd15;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] elapsed_ms;
		logic [14:0] msg_id;
		logic        guaranteed;
		logic        send_now;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [14:0] msg_id_res;
		logic [3:0]  slot;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [15:0] send_wait;
		logic [15:0] remove_timeout;
		logic [3:0]  retry_limit;
	} cfg_t;

	// item as broadcast along the cell row
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] elapsed_ms;
		logic [14:0] msg_id;
		logic        guaranteed;
		logic        send_now;
		logic [14:0] enq_id;
	} op_t;

	// report of the cell holding the token
	typedef struct packed {
		logic        hit;
		logic        emit;
		logic [2:0]  ev;
		logic [14:0] id;
	} cell_rep_t;

endpackage
`default_nettype wire

>>> rtl/core/rpt_cell.sv
// ----------------------------------------------------------------------------
// rpt_cell
// One slot of the pool: holds its state and acts while it holds the token.
// ----------------------------------------------------------------------------
`default_nettype none
module rpt_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              tok_in,
	input  wire logic              shift,
	input  wire rpt_pkg::op_t      op,
	input  wire rpt_pkg::cfg_t     cfg,
	input  wire logic              found,
	output logic                   tok,
	output rpt_pkg::cell_rep_t     rep
);

	logic        tok_q, valid_q, guar_q;
	logic [14:0] id_q;
	logic [3:0]  cnt_q;
	logic [15:0] st_q, rt_q;

	logic        valid_d, guar_d;
	logic [14:0] id_d;
	logic [3:0]  cnt_d;
	logic [15:0] st_d, rt_d;
	logic [16:0] st_sum, rt_sum;
	logic [15:0] st_sat, rt_sat;
	logic        over, fail, due;

	assign tok = tok_q;

	// age timers and work out this slot's action
	always_comb begin
		st_sum  = {1'b0, st_q} + {1'b0, op.elapsed_ms};
		rt_sum  = {1'b0, rt_q} + {1'b0, op.elapsed_ms};
		st_sat  = st_sum[16] ? 16'hFFFF : st_sum[15:0];
		rt_sat  = rt_sum[16] ? 16'hFFFF : rt_sum[15:0];
		over    = cnt_q > cfg.retry_limit;
		fail    = over && (rt_sat >= cfg.remove_timeout);
		due     = st_sat >= cfg.send_wait;
		valid_d = valid_q;
		guar_d  = guar_q;
		id_d    = id_q;
		cnt_d   = cnt_q;
		st_d    = st_q;
		rt_d    = rt_q;
		rep     = '0;
		rep.id  = id_q;
		case (op.kind)
			rpt_pkg::KIND_ENQ: begin
				if (!valid_q && !found) begin
					rep.hit = 1'b1;
					valid_d = 1'b1;
					id_d    = op.enq_id;
					guar_d  = op.guaranteed;
					cnt_d   = '0;
					st_d    = op.send_now ? cfg.send_wait : 16'd0;
					rt_d    = '0;
				end
			end
			rpt_pkg::KIND_TICK: begin
				if (valid_q) begin
					if (over) rt_d = rt_sat;
					if (fail) begin
						rep.emit = 1'b1;
						rep.ev   = rpt_pkg::EV_FAILED;
						valid_d  = 1'b0;
					end else begin
						st_d = st_sat;
						if (due) begin
							if (cnt_q != rpt_pkg::SEND_COUNT_MAX) cnt_d = cnt_q + 4'd1;
							rep.emit = 1'b1;
							rep.ev   = rpt_pkg::EV_SEND;
							if (!guar_q) valid_d = 1'b0;
							else st_d = '0;
						end
					end
				end
			end
			rpt_pkg::KIND_ACK: begin
				if (valid_q && id_q == op.msg_id) begin
					rep.hit = 1'b1;
					valid_d = 1'b0;
				end
			end
			rpt_pkg::KIND_NACK: begin
				if (valid_q && cnt_q != 4'd0 && id_q == op.msg_id && !found) begin
					rep.hit = 1'b1;
					cnt_d   = '0;
					st_d    = '0;
				end
			end
			default: begin
				rep = '0;
			end
		endcase
	end

	// pass the token on and hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (shift) tok_q <= tok_in;
			if (shift && tok_q) valid_q <= valid_d;
		end
	end

	// commit slot payload on leaving the cell
	always_ff @(posedge clk) begin
		if (shift && tok_q) begin
			guar_q <= guar_d;
			id_q   <= id_d;
			cnt_q  <= cnt_d;
			st_q   <= st_d;
			rt_q   <= rt_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/retransmit_pool_tracker_top.sv
// ----------------------------------------------------------------------------
// retransmit_pool_tracker_top
// Retransmission slot pool: a token walks a row of slot cells per item.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  cmd     | cmd_valid / cmd_stall    | cmd  (kind, elapsed_ms, msg_id, ...)
//  res     | res_valid / res_stall    | res  (event_res, msg_id_res, slot, last)
//  cfg     | cfg_we                   | cfg_index, cfg_data
//
// Each item is taken in a beat, then the token passes the cell row slot by slot,
// then the closing result is written to the output register.
// A cell's result that waits on res_stall holds the token where it is.
// The next beat is taken once the closing result sits in the output register.
// Reset clears all valid flags and the id counter and loads the registers with their defaults.
`default_nettype none
`include "retransmit_pool_tracker_top_assert.svh"
module retransmit_pool_tracker_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_stall,
	input  wire rpt_pkg::cmd_t cmd,
	output logic               res_valid,
	input  wire logic          res_stall,
	output rpt_pkg::res_t      res,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [15:0]   cfg_data
);

	typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FIN} state_t;

	state_t                           state_q;
	rpt_pkg::cfg_t                    cfg_q;
	rpt_pkg::op_t                     op_q;
	logic [14:0]                      next_id_q;
	logic                             found_q;
	logic [rpt_pkg::SIDX_W-1:0]       first_q;
	logic                             res_valid_q;
	rpt_pkg::res_t                    res_q;

	logic [rpt_pkg::SLOTS-1:0]        tok_vec, tok_in;
	rpt_pkg::cell_rep_t               rep_vec [rpt_pkg::SLOTS];
	rpt_pkg::cell_rep_t               sel;
	logic [rpt_pkg::SIDX_W-1:0]       sel_slot;
	logic [14:0]                      id_use;
	logic                             acc, res_free, step, shift_all;
	rpt_pkg::res_t                    fin_res;

	assign cmd_stall = state_q != ST_IDLE;
	assign acc       = cmd_valid && !cmd_stall;
	assign res_free  = !res_valid_q || !res_stall;
	assign step      = state_q == ST_WALK && (!sel.emit || res_free);
	assign shift_all = acc || step;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign id_use    = (next_id_q >= 15'(rpt_pkg::ID_WRAP)) ? 15'd0 : next_id_q;

	// build the cell row; the token enters at slot zero
	always_comb begin
		tok_in[0] = acc;
		for (int i = 1; i < rpt_pkg::SLOTS; i++) tok_in[i] = tok_vec[i-1];
	end

	for (genvar g = 0; g < rpt_pkg::SLOTS; g++) begin : g_cell
		rpt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_in (tok_in[g]),
			.shift  (shift_all),
			.op     (op_q),
			.cfg    (cfg_q),
			.found  (found_q),
			.tok    (tok_vec[g]),
			.rep    (rep_vec[g])
		);
	end

	// pick the report of the token holder
	always_comb begin
		sel      = '0;
		sel_slot = '0;
		for (int i = 0; i < rpt_pkg::SLOTS; i++) begin
			if (tok_vec[i]) begin
				sel      = sel | rep_vec[i];
				sel_slot = sel_slot | rpt_pkg::SIDX_W'(i);
			end
		end
	end

	// closing result of the item
	always_comb begin
		fin_res      = '0;
		fin_res.last = 1'b1;
		case (op_q.kind)
			rpt_pkg::KIND_ENQ: begin
				if (found_q) begin
					fin_res.event_res  = rpt_pkg::EV_ENQUEUED;
					fin_res.msg_id_res = op_q.enq_id;
					fin_res.slot       = 4'(first_q);
				end else begin
					fin_res.event_res  = rpt_pkg::EV_FULL;
				end
			end
			rpt_pkg::KIND_TICK: fin_res.event_res = rpt_pkg::EV_DONE;
			rpt_pkg::KIND_ACK: begin
				fin_res.event_res  = rpt_pkg::EV_SUCCESS;
				fin_res.msg_id_res = op_q.msg_id;
				fin_res.slot       = 4'(first_q);
			end
			rpt_pkg::KIND_NACK: begin
				fin_res.event_res  = rpt_pkg::EV_DONE;
				fin_res.msg_id_res = op_q.msg_id;
				fin_res.slot       = 4'(first_q);
			end
			default: fin_res.event_res = rpt_pkg::EV_DONE;
		endcase
	end

	// sequencer, registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q              <= ST_IDLE;
			cfg_q.send_wait      <= rpt_pkg::SEND_WAIT_RST;
			cfg_q.remove_timeout <= rpt_pkg::REMOVE_TIMEOUT_RST;
			cfg_q.retry_limit    <= rpt_pkg::RETRY_LIMIT_RST;
			next_id_q            <= '0;
			found_q              <= 1'b0;
			first_q              <= '0;
			res_valid_q          <= 1'b0;
			res_q                <= '0;
			op_q                 <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rpt_pkg::REG_SEND_WAIT:      cfg_q.send_wait      <= cfg_data;
					rpt_pkg::REG_REMOVE_TIMEOUT: cfg_q.remove_timeout <= cfg_data;
					rpt_pkg::REG_RETRY_LIMIT:    cfg_q.retry_limit    <= cfg_data[3:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (res_free) res_valid_q <= 1'b0;
					if (acc) begin
						op_q.kind       <= cmd.kind;
						op_q.elapsed_ms <= cmd.elapsed_ms;
						op_q.msg_id     <= cmd.msg_id;
						op_q.guaranteed <= cmd.guaranteed;
						op_q.send_now   <= cmd.send_now;
						op_q.enq_id     <= id_use;
						found_q         <= 1'b0;
						first_q         <= '0;
						state_q         <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (res_free && !(step && sel.emit)) res_valid_q <= 1'b0;
					if (step) begin
						if (sel.hit && !found_q) begin
							found_q <= 1'b1;
							first_q <= sel_slot;
						end
						if (sel.emit) begin
							res_valid_q      <= 1'b1;
							res_q.event_res  <= sel.ev;
							res_q.msg_id_res <= sel.id;
							res_q.slot       <= 4'(sel_slot);
							res_q.last       <= 1'b0;
						end
						if (tok_vec[rpt_pkg::SLOTS-1]) state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (res_free) begin
						res_valid_q <= 1'b1;
						res_q       <= fin_res;
						if (op_q.kind == rpt_pkg::KIND_ENQ && found_q)
							next_id_q <= op_q.enq_id + 15'd1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					if (res_free) res_valid_q <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`RPT_ASSERT_ALWAYS(a_tok_onehot, $onehot0(tok_vec), "token held by more than one cell")
	`RPT_ASSERT_IMPL(a_idle_no_tok, state_q == ST_IDLE, tok_vec == '0, "token live while idle")
	`RPT_ASSERT_NEXT(a_acc_tok, acc, tok_vec[0] && state_q == ST_WALK, "token not at slot zero")
	`RPT_ASSERT_NEXT(a_walk_no_last, state_q == ST_WALK && step && sel.emit, !res_q.last, "slot result marked last")

endmodule
`default_nettype wire

>>> test/retransmit_pool_tracker_top_tb.sv
// ----------------------------------------------------------------------------
// retransmit_pool_tracker_top_tb
// Drives enqueue, tick, ack and nack beats with random gaps and stalls,
// predicts every result from its own copy of the slot pool and checks them.
// ----------------------------------------------------------------------------
module retransmit_pool_tracker_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 300;

	logic clk, arst_n;
	logic cmd_valid, cmd_stall, res_valid, res_stall, cfg_we;
	rpt_pkg::cmd_t cmd;
	rpt_pkg::res_t res;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	retransmit_pool_tracker_top dut (.*);

	// predicted pool
	logic        pv [rpt_pkg::SLOTS];
	logic [14:0] pid [rpt_pkg::SLOTS];
	logic        pg [rpt_pkg::SLOTS];
	logic [3:0]  pcnt [rpt_pkg::SLOTS];
	logic [15:0] pst [rpt_pkg::SLOTS];
	logic [15:0] prt [rpt_pkg::SLOTS];
	logic [14:0] nid;
	logic [15:0] c_send, c_remove;
	logic [3:0]  c_retry;

	rpt_pkg::res_t pending_res [$];
	int errors = 0;
	int hold_reqs = 0;
	bit calm = 1'b0;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		int n;
		n = 0;
		forever begin
			@(posedge clk);
			n++;
			if (n > CYCLE_LIMIT) begin
				$display("FAIL retransmit_pool_tracker_top");
				$finish;
			end
		end
	end

	function automatic logic [15:0] sat16(logic [15:0] a, logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[16] ? 16'hffff : s[15:0];
	endfunction

	function automatic rpt_pkg::res_t mk(logic [2:0] e, logic [14:0] id, int s, logic l);
		rpt_pkg::res_t r;
		r.event_res = e; r.msg_id_res = id; r.slot = s[3:0]; r.last = l;
		return r;
	endfunction

	// work out the results of one item and update the pool
	task automatic predict_pool(rpt_pkg::cmd_t c);
		int i, first;
		bit found;
		case (c.kind)
			rpt_pkg::KIND_ENQ: begin
				for (i = 0; i < rpt_pkg::SLOTS; i++) if (!pv[i]) break;
				if (i == rpt_pkg::SLOTS)
					pending_res.push_back(mk(rpt_pkg::EV_FULL, 15'd0, 0, 1'b1));
				else begin
					if (nid >= 15'(rpt_pkg::ID_WRAP)) nid = 15'd0;
					pv[i] = 1'b1; pid[i] = nid; pg[i] = c.guaranteed; pcnt[i] = 4'd0;
					pst[i] = c.send_now ? c_send : 16'd0; prt[i] = 16'd0;
					pending_res.push_back(mk(rpt_pkg::EV_ENQUEUED, nid, i, 1'b1));
					nid = nid + 15'd1;
				end
			end
			rpt_pkg::KIND_TICK: begin
				for (i = 0; i < rpt_pkg::SLOTS; i++) begin
					if (!pv[i]) continue;
					if (pcnt[i] > c_retry) begin
						prt[i] = sat16(prt[i], c.elapsed_ms);
						if (prt[i] >= c_remove) begin
							pending_res.push_back(mk(rpt_pkg::EV_FAILED, pid[i], i, 1'b0));
							pv[i] = 1'b0;
							continue;
						end
					end
					pst[i] = sat16(pst[i], c.elapsed_ms);
					if (pst[i] >= c_send) begin
						if (pcnt[i] < rpt_pkg::SEND_COUNT_MAX) pcnt[i] = pcnt[i] + 4'd1;
						pending_res.push_back(mk(rpt_pkg::EV_SEND, pid[i], i, 1'b0));
						if (!pg[i]) pv[i] = 1'b0; else pst[i] = 16'd0;
					end
				end
				pending_res.push_back(mk(rpt_pkg::EV_DONE, 15'd0, 0, 1'b1));
			end
			rpt_pkg::KIND_ACK: begin
				first = 0; found = 0;
				for (i = 0; i < rpt_pkg::SLOTS; i++)
					if (pv[i] && pid[i] == c.msg_id) begin
						if (!found) begin first = i; found = 1; end
						pv[i] = 1'b0;
					end
				pending_res.push_back(mk(rpt_pkg::EV_SUCCESS, c.msg_id, first, 1'b1));
			end
			default: begin
				first = 0;
				for (i = 0; i < rpt_pkg::SLOTS; i++)
					if (pv[i] && pcnt[i] != 4'd0 && pid[i] == c.msg_id) begin
						pcnt[i] = 4'd0; pst[i] = 16'd0; first = i;
						break;
					end
				pending_res.push_back(mk(rpt_pkg::EV_DONE, c.msg_id, first, 1'b1));
			end
		endcase
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		rpt_pkg::res_t w;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_res.size() == 0) report_mismatch("unexpected beat", 32'(res), 32'd0);
			else begin
				w = pending_res.pop_front();
				if (res.event_res !== w.event_res)
					report_mismatch("event_res", 32'(res.event_res), 32'(w.event_res));
				if (res.msg_id_res !== w.msg_id_res)
					report_mismatch("msg_id_res", 32'(res.msg_id_res), 32'(w.msg_id_res));
				if (res.slot !== w.slot)
					report_mismatch("slot", 32'(res.slot), 32'(w.slot));
				if (res.last !== w.last)
					report_mismatch("last", 32'(res.last), 32'(w.last));
			end
		end
	end

	// receiver: random stalls, or a long hold-off when one is asked for
	initial begin
		int left, seen;
		left = 0;
		seen = 0;
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_reqs != seen) begin
				seen = hold_reqs;
				left = HOLD_CYCLES;
			end
			if (left > 0) begin
				left--;
				res_stall <= 1'b1;
			end else res_stall <= calm ? 1'b0 : ($urandom_range(99) < 31);
		end
	end

	// send one beat, predicting its results when accepted
	task automatic send_item(rpt_pkg::cmd_t c);
		if (!calm) while ($urandom_range(99) < 31) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
		predict_pool(c);
	endtask

	function automatic rpt_pkg::cmd_t make_cmd(logic [1:0] k, logic [15:0] e, logic [14:0] id,
			logic g, logic n);
		rpt_pkg::cmd_t c;
		c.kind = k; c.elapsed_ms = e; c.msg_id = id; c.guaranteed = g; c.send_now = n;
		return c;
	endfunction

	task automatic drain_results();
		cmd_valid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] v);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			rpt_pkg::REG_SEND_WAIT:      c_send = v;
			rpt_pkg::REG_REMOVE_TIMEOUT: c_remove = v;
			rpt_pkg::REG_RETRY_LIMIT:    c_retry = v[3:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [14:0] live_id();
		int i;
		i = $urandom_range(rpt_pkg::SLOTS - 1);
		if (pv[i] && $urandom_range(3) != 0) return pid[i];
		return ($urandom_range(3) == 0) ? 15'(rpt_pkg::ID_WRAP - 1)
			: 15'($urandom_range(40));
	endfunction

	// mostly well-formed traffic on a partly filled pool
	task automatic random_traffic(int n);
		logic [15:0] e;
		repeat (n) begin
			case ($urandom_range(9))
				0, 1, 2, 3: send_item(make_cmd(rpt_pkg::KIND_ENQ, 16'($urandom),
					15'($urandom), 1'($urandom), 1'($urandom)));
				4, 5: begin
					e = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(30));
					send_item(make_cmd(rpt_pkg::KIND_TICK, e, 15'($urandom),
						1'($urandom), 1'($urandom)));
				end
				6, 7: send_item(make_cmd(rpt_pkg::KIND_ACK, 16'($urandom), live_id(),
					1'($urandom), 1'($urandom)));
				default: send_item(make_cmd(rpt_pkg::KIND_NACK, 16'($urandom), live_id(),
					1'($urandom), 1'($urandom)));
			endcase
		end
	endtask

	task automatic test_directed();
		int i;
		send_item(make_cmd(rpt_pkg::KIND_ACK, 16'd0, 15'h7fff, 1'b0, 1'b0));
		send_item(make_cmd(rpt_pkg::KIND_NACK, 16'hffff, 15'd0, 1'b1, 1'b1));
		send_item(make_cmd(rpt_pkg::KIND_ENQ, 16'hffff, 15'h7fff, 1'b1, 1'b1));
		send_item(make_cmd(rpt_pkg::KIND_ENQ, 16'd0, 15'd0, 1'b0, 1'b0));
		send_item(make_cmd(rpt_pkg::KIND_TICK, 16'd0, 15'd0, 1'b0, 1'b0));
		send_item(make_cmd(rpt_pkg::KIND_TICK, 16'd10, 15'd0, 1'b0, 1'b0));
		send_item(make_cmd(rpt_pkg::KIND_NACK, 16'd0, 15'd0, 1'b0, 1'b0));
		send_item(make_cmd(rpt_pkg::KIND_TICK, 16'hffff, 15'd0, 1'b0, 1'b0));
		send_item(make_cmd(rpt_pkg::KIND_TICK, 16'hffff, 15'd0, 1'b0, 1'b0));
		for (i = 0; i < rpt_pkg::SLOTS + 1; i++)
			send_item(make_cmd(rpt_pkg::KIND_ENQ, 16'd0, 15'd0, i[0], 1'b1));
		send_item(make_cmd(rpt_pkg::KIND_ACK, 16'd0, 15'd2, 1'b0, 1'b0));
		drain_results();
	endtask

	// zero timeouts and saturating send count, then maximum timeouts
	task automatic test_config_extremes();
		write_reg(rpt_pkg::REG_SEND_WAIT, 16'd0);
		write_reg(rpt_pkg::REG_REMOVE_TIMEOUT, 16'd0);
		write_reg(rpt_pkg::REG_RETRY_LIMIT, 16'd15);
		random_traffic(60);
		drain_results();
		write_reg(rpt_pkg::REG_RETRY_LIMIT, 16'd0);
		random_traffic(60);
		drain_results();
		write_reg(rpt_pkg::REG_SEND_WAIT, 16'hffff);
		write_reg(rpt_pkg::REG_REMOVE_TIMEOUT, 16'hffff);
		write_reg(rpt_pkg::REG_RETRY_LIMIT, 16'd14);
		random_traffic(50);
		drain_results();
	endtask

	// hold the receiver off so the block backs up its input
	task automatic test_backpressure();
		write_reg(rpt_pkg::REG_SEND_WAIT, 16'd5);
		write_reg(rpt_pkg::REG_REMOVE_TIMEOUT, 16'd20);
		write_reg(rpt_pkg::REG_RETRY_LIMIT, 16'd1);
		hold_reqs++;
		random_traffic(30);
		drain_results();
	endtask

	task automatic test_random();
		write_reg(rpt_pkg::REG_SEND_WAIT, 16'd12);
		write_reg(rpt_pkg::REG_REMOVE_TIMEOUT, 16'd40);
		write_reg(rpt_pkg::REG_RETRY_LIMIT, 16'd2);
		random_traffic(120);
		calm = 1'b1;
		random_traffic(60);
		calm = 1'b0;
		random_traffic(80);
		drain_results();
	endtask

	initial begin
		int i;
		arst_n = 0; cmd_valid = 0; cmd = '0; cfg_we = 0;
		cfg_index = '0; cfg_data = '0;
		for (i = 0; i < rpt_pkg::SLOTS; i++) begin
			pv[i] = 0; pid[i] = 0; pg[i] = 0; pcnt[i] = 0; pst[i] = 0; prt[i] = 0;
		end
		nid = 0;
		c_send = rpt_pkg::SEND_WAIT_RST;
		c_remove = rpt_pkg::REMOVE_TIMEOUT_RST;
		c_retry = rpt_pkg::RETRY_LIMIT_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_backpressure();
		test_random();
		drain_results();
		if (errors == 0) $display("PASS retransmit_pool_tracker_top");
		else $display("FAIL retransmit_pool_tracker_top");
		$finish;
	end
endmodule
